FILE: hdl/lce_pkg.sv
// Shared constants, payload types, control codes and state type for the convolution engine.
`timescale 1ns / 1ps

package lce_pkg;

    localparam int MAX_SIGNAL    = 32;
    localparam int MAX_KERNEL    = 32;
    localparam int SAMPLE_BITS   = 16;
    localparam int VAL_BITS      = 37;
    localparam int IDX_BITS      = 6;
    localparam int LEN_BITS      = 6;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;
    localparam int SIG_ADDR_BITS = (MAX_SIGNAL > 1) ? $clog2(MAX_SIGNAL) : 1;
    localparam int KER_ADDR_BITS = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] ACT_LOAD_SIGNAL = 2'd0;
    localparam logic [1:0] ACT_LOAD_KERNEL = 2'd1;
    localparam logic [1:0] ACT_COMPUTE     = 2'd2;
    localparam logic [1:0] ACT_NONE        = 2'd3;

    localparam logic [1:0] REG_SIGNAL_LENGTH = 2'd0;
    localparam logic [1:0] REG_KERNEL_LENGTH = 2'd1;
    localparam logic [1:0] REG_OUTPUT_MODE   = 2'd2;
    localparam logic [1:0] REG_UNUSED        = 2'd3;

    typedef struct packed {
        logic [1:0]                    action;
        logic signed [SAMPLE_BITS-1:0] sample;
    } lce_in_t;

    typedef struct packed {
        logic signed [VAL_BITS-1:0] conv_value;
        logic [IDX_BITS-1:0]        out_index;
        logic                       last;
    } lce_out_t;

    // Tag that travels with each product term down the MAC pipeline
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last_term;
        logic                last_out;
        logic [IDX_BITS-1:0] n;
    } lce_tag_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } lce_state_t;

endpackage

FILE: hdl/lce_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module lce_ram #(
    parameter int DEPTH      = 32,
    parameter int WIDTH      = 16,
    parameter int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/lce_mac.sv
// Multiply-accumulate pipeline: product stage, then accumulate and close each output sum.
`timescale 1ns / 1ps

module lce_mac import lce_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  lce_tag_t               tag_in,
    input  logic [SAMPLE_BITS-1:0] sig_q,
    input  logic [SAMPLE_BITS-1:0] ker_q,
    output logic                   res_valid,
    output lce_out_t               res
);

    lce_tag_t                    tag1_reg;
    lce_tag_t                    tag2_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [VAL_BITS-1:0]  acc_reg;
    logic signed [VAL_BITS-1:0]  acc_next;
    logic signed [VAL_BITS-1:0]  prod_ext;

    // tag1 lines up with the RAM read data, tag2 with the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else if (advance)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= $signed(sig_q) * $signed(ker_q);
        end
    end

    always_comb
    begin
        prod_ext = VAL_BITS'(prod_reg);
        if (tag2_reg.first)
        begin
            acc_next = prod_ext;
        end
        else
        begin
            acc_next = acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tag2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign res_valid      = tag2_reg.valid && tag2_reg.last_term;
    assign res.conv_value = acc_next;
    assign res.out_index  = tag2_reg.n;
    assign res.last       = tag2_reg.last_out;

endmodule

FILE: hdl/linear_convolution_engine.sv
// Load items fill the signal and kernel RAMs; one output register.
// A compute walks one product term per cycle while the output is not held: ls*lk terms in full mode, fewer truncated.
// After the compute beat, the first result goes through the RAM read, the product register and the output register.
// An output stall with a result held freezes the term walk and the MAC pipeline; inputs wait until the walk ends.
// Reset clears lengths to 32, mode to full, both fills and the sequencer; RAMs stay as they are.
`timescale 1ns / 1ps

module linear_convolution_engine import lce_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  lce_in_t                  in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output lce_out_t                 out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    logic [LEN_BITS-1:0] signal_length_reg;
    logic [LEN_BITS-1:0] kernel_length_reg;
    logic                output_mode_reg;
    logic [LEN_BITS-1:0] signal_fill_reg;
    logic [LEN_BITS-1:0] kernel_fill_reg;
    logic [LEN_BITS-1:0] signal_fill_next;
    logic [LEN_BITS-1:0] kernel_fill_next;

    lce_state_t          state_reg;
    lce_state_t          state_next;
    logic [IDX_BITS-1:0] n_reg;
    logic [IDX_BITS-1:0] n_next;
    logic [IDX_BITS-1:0] k_reg;
    logic [IDX_BITS-1:0] k_next;

    logic                out_valid_reg;
    lce_out_t            out_reg;

    logic                cfg_write;
    logic [1:0]          cfg_index;
    logic                in_fire;
    logic                advance;
    logic                issue;
    logic [LEN_BITS-1:0] ls_eff;
    logic [LEN_BITS-1:0] lk_eff;
    logic [IDX_BITS-1:0] ls_m1;
    logic [IDX_BITS-1:0] lk_m1;
    logic [IDX_BITS:0]   count_full;
    logic [IDX_BITS-1:0] last_n;
    logic [IDX_BITS-1:0] kmax;
    logic [IDX_BITS-1:0] n_plus1;
    logic [IDX_BITS-1:0] kmin_next;
    logic [IDX_BITS-1:0] j_idx;
    logic                term_last;
    logic                sig_we;
    logic                ker_we;
    lce_tag_t            tag_issue;
    logic [SAMPLE_BITS-1:0] sig_q;
    logic [SAMPLE_BITS-1:0] ker_q;
    logic                res_valid;
    lce_out_t            res;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signal_length_reg <= LEN_BITS'(32);
            kernel_length_reg <= LEN_BITS'(32);
            output_mode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SIGNAL_LENGTH: signal_length_reg <= pwdata[LEN_BITS-1:0];
                REG_KERNEL_LENGTH: kernel_length_reg <= pwdata[LEN_BITS-1:0];
                REG_OUTPUT_MODE:   output_mode_reg   <= pwdata[0];
                REG_UNUSED:        ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_SIGNAL_LENGTH: prdata[LEN_BITS-1:0] = signal_length_reg;
            REG_KERNEL_LENGTH: prdata[LEN_BITS-1:0] = kernel_length_reg;
            REG_OUTPUT_MODE:   prdata[0]            = output_mode_reg;
            REG_UNUSED:        prdata               = '0;
        endcase
    end

    // ---------------- effective lengths ----------------
    always_comb
    begin
        priority if (signal_length_reg == '0)
            ls_eff = LEN_BITS'(1);
        else if (signal_length_reg > LEN_BITS'(MAX_SIGNAL))
            ls_eff = LEN_BITS'(MAX_SIGNAL);
        else
            ls_eff = signal_length_reg;

        priority if (kernel_length_reg == '0)
            lk_eff = LEN_BITS'(1);
        else if (kernel_length_reg > LEN_BITS'(MAX_KERNEL))
            lk_eff = LEN_BITS'(MAX_KERNEL);
        else
            lk_eff = kernel_length_reg;
    end

    assign ls_m1      = IDX_BITS'(ls_eff - LEN_BITS'(1));
    assign lk_m1      = IDX_BITS'(lk_eff - LEN_BITS'(1));
    assign count_full = (IDX_BITS+1)'(ls_eff) + (IDX_BITS+1)'(lk_eff) - (IDX_BITS+1)'(1);
    assign last_n     = output_mode_reg ? ls_m1 : IDX_BITS'(count_full - (IDX_BITS+1)'(1));

    // ---------------- input side ----------------
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;

    assign sig_we = in_fire && (in_data.action == ACT_LOAD_SIGNAL) && (signal_fill_reg < ls_eff);
    assign ker_we = in_fire && (in_data.action == ACT_LOAD_KERNEL) && (kernel_fill_reg < lk_eff);

    always_comb
    begin
        signal_fill_next = signal_fill_reg;
        kernel_fill_next = kernel_fill_reg;
        if (sig_we)
        begin
            signal_fill_next = signal_fill_reg + LEN_BITS'(1);
        end
        if (ker_we)
        begin
            kernel_fill_next = kernel_fill_reg + LEN_BITS'(1);
        end
        if (in_fire && (in_data.action == ACT_COMPUTE))
        begin
            signal_fill_next = '0;
            kernel_fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signal_fill_reg <= '0;
            kernel_fill_reg <= '0;
        end
        else
        begin
            signal_fill_reg <= signal_fill_next;
            kernel_fill_reg <= kernel_fill_next;
        end
    end

    // ---------------- term sequencer ----------------
    // Hold everything while a finished result sits in the output register unaccepted
    assign advance = !out_valid_reg || !out_stall;
    assign issue   = (state_reg == ST_RUN) && advance;

    assign kmax      = (n_reg < ls_m1) ? n_reg : ls_m1;
    assign n_plus1   = n_reg + IDX_BITS'(1);
    assign kmin_next = (n_plus1 >= lk_m1) ? (n_plus1 - lk_m1) : '0;
    assign j_idx     = n_reg - k_reg;
    assign term_last = (k_reg == kmax);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_data.action == ACT_COMPUTE))
                begin
                    state_next = ST_RUN;
                    n_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    if (!term_last)
                    begin
                        k_next = k_reg + IDX_BITS'(1);
                    end
                    else if (n_reg == last_n)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        n_next = n_plus1;
                        k_next = kmin_next;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        tag_issue.valid     = issue;
        tag_issue.first     = (k_reg == ((n_reg >= lk_m1) ? (n_reg - lk_m1) : '0));
        tag_issue.last_term = term_last;
        tag_issue.last_out  = term_last && (n_reg == last_n);
        tag_issue.n         = n_reg;
    end

    // ---------------- stores ----------------
    lce_ram #(
        .DEPTH     (MAX_SIGNAL),
        .WIDTH     (SAMPLE_BITS),
        .ADDR_BITS (SIG_ADDR_BITS)
    ) u_signal_ram (
        .clk   (clk),
        .we    (sig_we),
        .waddr (signal_fill_reg[SIG_ADDR_BITS-1:0]),
        .wdata (in_data.sample),
        .re    (advance),
        .raddr (k_reg[SIG_ADDR_BITS-1:0]),
        .rdata (sig_q)
    );

    lce_ram #(
        .DEPTH     (MAX_KERNEL),
        .WIDTH     (SAMPLE_BITS),
        .ADDR_BITS (KER_ADDR_BITS)
    ) u_kernel_ram (
        .clk   (clk),
        .we    (ker_we),
        .waddr (kernel_fill_reg[KER_ADDR_BITS-1:0]),
        .wdata (in_data.sample),
        .re    (advance),
        .raddr (j_idx[KER_ADDR_BITS-1:0]),
        .rdata (ker_q)
    );

    // ---------------- MAC pipeline ----------------
    lce_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .tag_in    (tag_issue),
        .sig_q     (sig_q),
        .ker_q     (ker_q),
        .res_valid (res_valid),
        .res       (res)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: test/tb_linear_convolution_engine.sv
// Self-checking testbench for linear_convolution_engine: directed and random beats.
`timescale 1ns / 1ps

module tb_linear_convolution_engine;
    import lce_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;

    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    lce_in_t                  in_data   = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    lce_out_t                 out_data;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr     = '0;
    logic [APB_DATA_BITS-1:0] pwdata    = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    linear_convolution_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Predictor state: register copies, stores, fill positions
    logic [LEN_BITS-1:0]           cfg_signal_len = LEN_BITS'(32);
    logic [LEN_BITS-1:0]           cfg_kernel_len = LEN_BITS'(32);
    logic                          cfg_mode       = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sig_mem [MAX_SIGNAL];
    logic signed [SAMPLE_BITS-1:0] ker_mem [MAX_KERNEL];
    bit                            sig_written [MAX_SIGNAL];
    bit                            ker_written [MAX_KERNEL];
    int                            sig_fill = 0;
    int                            ker_fill = 0;

    lce_out_t conv_expected [$];

    int send_idle_pct   = 0;
    int stall_pct       = 0;
    int hold_len        = 0;
    int hold_seq        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int beats_accepted  = 0;
    int beats_used      = 0;
    int computes        = 0;
    int results_checked = 0;
    int mismatches      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, conv_expected.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= hold_len - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        lce_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (conv_expected.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: value %0d index %0d last %0d",
                             out_data.conv_value, out_data.out_index, out_data.last);
                mismatches++;
            end
            else
            begin
                want = conv_expected.pop_front();
                if (out_data.conv_value !== want.conv_value
                        || out_data.out_index !== want.out_index
                        || out_data.last !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $write("result %0d: expected value %0d index %0d last %0d,",
                               results_checked, want.conv_value, want.out_index,
                               want.last);
                        $display(" got value %0d index %0d last %0d",
                                 out_data.conv_value, out_data.out_index, out_data.last);
                    end
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    function automatic int eff_len(logic [LEN_BITS-1:0] raw, int depth);
        if (raw == 0)
            return 1;
        if (int'(raw) > depth)
            return depth;
        return int'(raw);
    endfunction

    // True when every store position the next compute reads has been written
    function automatic bit stores_ready();
        int ls;
        int lk;
        ls = eff_len(cfg_signal_len, MAX_SIGNAL);
        lk = eff_len(cfg_kernel_len, MAX_KERNEL);
        for (int k = 0; k < ls; k++)
            if (!sig_written[k])
                return 1'b0;
        for (int k = 0; k < lk; k++)
            if (!ker_written[k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Update the store model for one beat and queue the convolution it produces
    task automatic conv_predict(lce_in_t beat);
        int ls;
        int lk;
        int count;
        int kmin;
        int kmax;
        logic signed [63:0] acc;
        lce_out_t res;
        ls = eff_len(cfg_signal_len, MAX_SIGNAL);
        lk = eff_len(cfg_kernel_len, MAX_KERNEL);
        beats_accepted++;
        case (beat.action)
            ACT_LOAD_SIGNAL:
            begin
                if (sig_fill < ls)
                begin
                    sig_mem[sig_fill]     = beat.sample;
                    sig_written[sig_fill] = 1'b1;
                    sig_fill++;
                    beats_used++;
                end
            end
            ACT_LOAD_KERNEL:
            begin
                if (ker_fill < lk)
                begin
                    ker_mem[ker_fill]     = beat.sample;
                    ker_written[ker_fill] = 1'b1;
                    ker_fill++;
                    beats_used++;
                end
            end
            ACT_COMPUTE:
            begin
                count = cfg_mode ? ls : ls + lk - 1;
                for (int n = 0; n < count; n++)
                begin
                    kmin = (n >= lk - 1) ? n - (lk - 1) : 0;
                    kmax = (n < ls - 1) ? n : ls - 1;
                    acc  = '0;
                    for (int k = kmin; k <= kmax; k++)
                        acc = acc + sig_mem[k] * ker_mem[n - k];
                    res.conv_value = acc[VAL_BITS-1:0];
                    res.out_index  = IDX_BITS'(n);
                    res.last       = (n == count - 1);
                    conv_expected.push_back(res);
                end
                sig_fill = 0;
                ker_fill = 0;
                computes++;
                beats_used++;
            end
            default: ;
        endcase
    endtask

    task automatic send_beat(logic [1:0] action, logic signed [SAMPLE_BITS-1:0] sample);
        lce_in_t beat;
        beat.action = action;
        beat.sample = sample;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        conv_predict(beat);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (conv_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (reg_idx)
            REG_SIGNAL_LENGTH: cfg_signal_len = value[LEN_BITS-1:0];
            REG_KERNEL_LENGTH: cfg_kernel_len = value[LEN_BITS-1:0];
            REG_OUTPUT_MODE:   cfg_mode       = value[0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return -16'sd1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly short lengths, some full depth, and a few out-of-range codes
    function automatic logic [31:0] length_word();
        int pick;
        logic [LEN_BITS-1:0] raw;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            raw = '0;
        else if (pick == 1)
            raw = LEN_BITS'($urandom_range(33, 63));
        else if (pick < 4)
            raw = LEN_BITS'(32);
        else if (pick < 6)
            raw = LEN_BITS'($urandom_range(9, 31));
        else
            raw = LEN_BITS'($urandom_range(1, 8));
        return ({$urandom} & ~32'h3F) | {26'd0, raw};
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0:       send_beat(ACT_LOAD_SIGNAL, rand_sample());
            1:       send_beat(ACT_LOAD_KERNEL, rand_sample());
            default: send_beat(ACT_NONE, rand_sample());
        endcase
    endtask

    task automatic test_extremes();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(REG_SIGNAL_LENGTH, 32'd1);
        write_reg(REG_KERNEL_LENGTH, 32'd1);
        write_reg(REG_OUTPUT_MODE, 32'd0);
        send_beat(ACT_LOAD_SIGNAL, SAMPLE_MIN);
        send_beat(ACT_LOAD_KERNEL, SAMPLE_MIN);
        send_beat(ACT_COMPUTE, SAMPLE_MAX);
        send_beat(ACT_LOAD_SIGNAL, SAMPLE_MAX);
        send_beat(ACT_LOAD_KERNEL, SAMPLE_MIN);
        send_beat(ACT_COMPUTE, 16'sd0);
    endtask

    // Unused action, loads past the length, interleaved loads
    task automatic test_actions();
        write_reg(REG_SIGNAL_LENGTH, 32'd2);
        write_reg(REG_KERNEL_LENGTH, 32'd3);
        send_beat(ACT_LOAD_SIGNAL, 16'sd12345);
        send_beat(ACT_NONE, SAMPLE_MIN);
        send_beat(ACT_LOAD_KERNEL, -16'sd2);
        send_beat(ACT_LOAD_SIGNAL, SAMPLE_MIN);
        send_beat(ACT_LOAD_SIGNAL, SAMPLE_MAX);
        send_beat(ACT_LOAD_KERNEL, SAMPLE_MAX);
        send_beat(ACT_LOAD_KERNEL, 16'sd1);
        send_beat(ACT_LOAD_KERNEL, SAMPLE_MIN);
        send_beat(ACT_COMPUTE, -16'sd1);
    endtask

    task automatic test_truncated();
        write_reg(REG_OUTPUT_MODE, 32'hFFFF_FFFF);
        write_reg(REG_SIGNAL_LENGTH, 32'd3);
        write_reg(REG_KERNEL_LENGTH, 32'd2);
        send_beat(ACT_LOAD_SIGNAL, 16'sh5555);
        send_beat(ACT_LOAD_SIGNAL, 16'shAAAA);
        send_beat(ACT_LOAD_KERNEL, 16'sh0F0F);
        send_beat(ACT_LOAD_SIGNAL, 16'sh00FF);
        send_beat(ACT_LOAD_KERNEL, 16'shF0F0);
        send_beat(ACT_COMPUTE, 16'sd0);
        // signal shorter than kernel, reuse the held store contents
        write_reg(REG_SIGNAL_LENGTH, 32'd2);
        write_reg(REG_KERNEL_LENGTH, 32'd3);
        send_beat(ACT_COMPUTE, 16'sd0);
    endtask

    task automatic test_unused_register();
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_beat(ACT_COMPUTE, 16'sd0);
    endtask

    // Full depth: all-min samples give the largest sum and the highest index
    task automatic test_full_scale();
        send_idle_pct = 37;
        stall_pct     = 37;
        write_reg(REG_SIGNAL_LENGTH, 32'd32);
        write_reg(REG_KERNEL_LENGTH, 32'd32);
        write_reg(REG_OUTPUT_MODE, 32'd0);
        for (int i = 0; i < MAX_SIGNAL; i++)
            send_beat(ACT_LOAD_SIGNAL, SAMPLE_MIN);
        for (int i = 0; i < MAX_KERNEL; i++)
            send_beat(ACT_LOAD_KERNEL, SAMPLE_MIN);
        send_beat(ACT_COMPUTE, 16'sd0);
        for (int i = 0; i < MAX_KERNEL; i++)
            send_beat(ACT_LOAD_KERNEL, SAMPLE_MAX);
        send_beat(ACT_COMPUTE, 16'sd0);
    endtask

    // Length zero reads as one, lengths above the depth read as the depth
    task automatic test_length_clamp();
        send_idle_pct = 0;
        stall_pct     = 0;
        write_reg(REG_SIGNAL_LENGTH, 32'hABCD_EF00);
        write_reg(REG_KERNEL_LENGTH, 32'd63);
        send_beat(ACT_LOAD_SIGNAL, SAMPLE_MAX);
        send_beat(ACT_LOAD_SIGNAL, SAMPLE_MIN);
        send_beat(ACT_COMPUTE, 16'sd0);
        write_reg(REG_SIGNAL_LENGTH, 32'hFFFF_FFFF);
        write_reg(REG_KERNEL_LENGTH, 32'd0);
        send_beat(ACT_COMPUTE, 16'sd0);
        write_reg(REG_OUTPUT_MODE, 32'd1);
        write_reg(REG_SIGNAL_LENGTH, 32'd0);
        send_beat(ACT_COMPUTE, 16'sd0);
        write_reg(REG_OUTPUT_MODE, 32'd0);
    endtask

    // Hold the output off long enough that the walk freezes and input backs up
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 20;
        write_reg(REG_SIGNAL_LENGTH, 32'd32);
        write_reg(REG_KERNEL_LENGTH, 32'd32);
        hold_len = 600;
        hold_seq++;
        send_beat(ACT_COMPUTE, 16'sd0);
        send_beat(ACT_COMPUTE, 16'sd0);
        for (int i = 0; i < 5; i++)
        begin
            send_beat(ACT_LOAD_SIGNAL, rand_sample());
            send_beat(ACT_LOAD_KERNEL, rand_sample());
        end
        send_beat(ACT_COMPUTE, 16'sd0);
        // sender pauses until the block has drained
        wait_idle();
        send_beat(ACT_COMPUTE, 16'sd0);
    endtask

    task automatic run_random_phase(int idle, int stall, int quota);
        int goal;
        int kind;
        int ls;
        int lk;
        int n_sig;
        int n_ker;
        send_idle_pct = idle;
        stall_pct     = stall;
        goal = beats_used + quota;
        while (beats_used < goal)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(REG_SIGNAL_LENGTH, length_word());
                write_reg(REG_KERNEL_LENGTH, length_word());
                write_reg(REG_OUTPUT_MODE, ({$urandom} & ~32'd1) | $urandom_range(0, 1));
            end
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 4)) send_noise();
            end
            else
            begin
                ls = eff_len(cfg_signal_len, MAX_SIGNAL);
                lk = eff_len(cfg_kernel_len, MAX_KERNEL);
                n_sig = (ls > sig_fill) ? ls - sig_fill : 0;
                n_ker = (lk > ker_fill) ? lk - ker_fill : 0;
                // a broken set stops loading early
                if (kind == 1)
                begin
                    n_sig = $urandom_range(0, n_sig);
                    n_ker = $urandom_range(0, n_ker);
                end
                while (n_sig + n_ker > 0)
                begin
                    if ($urandom_range(0, 24) == 0)
                        send_noise();
                    if (n_sig > 0 && (n_ker == 0 || $urandom_range(0, 1) == 1))
                    begin
                        send_beat(ACT_LOAD_SIGNAL, rand_sample());
                        n_sig--;
                    end
                    else
                    begin
                        send_beat(ACT_LOAD_KERNEL, rand_sample());
                        n_ker--;
                    end
                end
                if ($urandom_range(0, 4) == 0)
                    send_beat($urandom_range(0, 1) ? ACT_LOAD_SIGNAL : ACT_LOAD_KERNEL,
                              rand_sample());
                if (stores_ready())
                    send_beat(ACT_COMPUTE, rand_sample());
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_actions();
        test_truncated();
        test_unused_register();
        test_full_scale();
        test_length_clamp();
        test_backpressure();
        run_random_phase(0, 0, 60);
        run_random_phase(76, 0, 60);
        run_random_phase(0, 76, 60);
        run_random_phase(37, 37, 60);
        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d beats (%0d stored or computed), %0d computes, %0d results",
                 beats_accepted, beats_used, computes, results_checked);
        $display("lengths 0..63 with clamping, both output modes, idle gaps, output hold-off");
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
